### design/fcull_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types and constants of the frustum culling test: plane layout,
// coordinate bundles and the arithmetic widths of the distance path.
// ----------------------------------------------------------------------------
package fcull_pkg;

	localparam int PLANE_COUNT  = 6;
	localparam int COORD_W      = 16;
	localparam int COEF_W       = 16;
	localparam int RADIUS_W     = 15;
	localparam int PROD_W       = COORD_W + COEF_W;
	localparam int OFFSET_SHIFT = 14;
	localparam int DIST_W       = 35;
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int OFS_PAD_W    = DIST_W - COEF_W - OFFSET_SHIFT;
	localparam int RAD_PAD_W    = DIST_W - RADIUS_W - OFFSET_SHIFT;
	localparam int PROD_PAD_W   = DIST_W - PROD_W;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;

	localparam logic MODE_SPHERE = 1'b0;
	localparam logic MODE_BOX    = 1'b1;

	typedef struct packed {
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] a;
	} plane_t;

	typedef plane_t [PLANE_COUNT-1:0] plane_set_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} coord_t;

	typedef struct packed {
		logic                mode;
		logic [RADIUS_W-1:0] radius;
	} stage_ctrl_t;

endpackage

### design/fcull_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_cfg_regs
// Holds the six packed frustum planes written over the configuration port.
// ----------------------------------------------------------------------------
module fcull_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fcull_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fcull_pkg::CFG_W-1:0]     cfg_wdata,
	output fcull_pkg::plane_set_t           planes
);
	import fcull_pkg::*;

	plane_set_t planes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PLANE_LEFT:   planes_q[0] <= plane_t'(cfg_wdata);
				REG_PLANE_RIGHT:  planes_q[1] <= plane_t'(cfg_wdata);
				REG_PLANE_BOTTOM: planes_q[2] <= plane_t'(cfg_wdata);
				REG_PLANE_TOP:    planes_q[3] <= plane_t'(cfg_wdata);
				REG_PLANE_NEAR:   planes_q[4] <= plane_t'(cfg_wdata);
				REG_PLANE_FAR:    planes_q[5] <= plane_t'(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	assign planes = planes_q;

endmodule

### design/fcull_plane_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_plane_unit
// Tests one plane: registers the three per-axis products, then sums them
// with the scaled offset and compares against the sphere or box bound.
// ----------------------------------------------------------------------------
module fcull_plane_unit (
	input  logic                   clk,
	input  fcull_pkg::plane_t      plane,
	input  logic                   mode_s1,
	input  fcull_pkg::coord_t      lo_s1,
	input  fcull_pkg::coord_t      hi_s1,
	input  fcull_pkg::stage_ctrl_t ctrl_s2,
	output logic                   plane_ok
);
	import fcull_pkg::*;

	logic signed [PROD_W-1:0] px_lo, px_hi, py_lo, py_hi, pz_lo, pz_hi;
	logic signed [PROD_W-1:0] tx_s2, ty_s2, tz_s2;
	logic signed [DIST_W-1:0] dist_sum;
	logic signed [DIST_W-1:0] ofs;
	logic signed [DIST_W-1:0] rad;
	logic signed [DIST_W-1:0] margin;

	assign px_lo = lo_s1.x * plane.a;
	assign px_hi = hi_s1.x * plane.a;
	assign py_lo = lo_s1.y * plane.b;
	assign py_hi = hi_s1.y * plane.b;
	assign pz_lo = lo_s1.z * plane.c;
	assign pz_hi = hi_s1.z * plane.c;

	// In box mode each axis takes the corner that maximizes its term, so the
	// sum is the largest distance over all eight corners.
	always_ff @(posedge clk) begin
		tx_s2 <= (mode_s1 == MODE_BOX && px_hi > px_lo) ? px_hi : px_lo;
		ty_s2 <= (mode_s1 == MODE_BOX && py_hi > py_lo) ? py_hi : py_lo;
		tz_s2 <= (mode_s1 == MODE_BOX && pz_hi > pz_lo) ? pz_hi : pz_lo;
	end

	assign ofs  = {{OFS_PAD_W{plane.d[COEF_W-1]}}, plane.d, {OFFSET_SHIFT{1'b0}}};
	assign rad  = {{RAD_PAD_W{1'b0}}, ctrl_s2.radius, {OFFSET_SHIFT{1'b0}}};
	assign dist_sum = {{PROD_PAD_W{tx_s2[PROD_W-1]}}, tx_s2}
	                + {{PROD_PAD_W{ty_s2[PROD_W-1]}}, ty_s2}
	                + {{PROD_PAD_W{tz_s2[PROD_W-1]}}, tz_s2}
	                + ofs;
	assign margin = dist_sum + rad;

	always_comb begin
		if (ctrl_s2.mode == MODE_BOX) begin
			plane_ok = (dist_sum > $signed({DIST_W{1'b0}}));
		end else begin
			plane_ok = !margin[DIST_W-1];
		end
	end

endmodule

### design/frustum_cull_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_test
// Tests a sphere or an axis-aligned box against six stored frustum planes
// and reports whether the volume may be visible.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  input     start, busy           mode, first_*, second_*, radius
//  result    done (one cycle)      visible
//  config    cfg_we                cfg_index, cfg_wdata
//
// One transaction is accepted every cycle; busy is always low.
// After acceptance a transaction passes the input register, the product
// register of the six plane units, then the visible register.
// Reset clears the planes to zero and empties the pipeline.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module frustum_cull_test (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              mode,
	input  logic signed [fcull_pkg::COORD_W-1:0] first_x,
	input  logic signed [fcull_pkg::COORD_W-1:0] first_y,
	input  logic signed [fcull_pkg::COORD_W-1:0] first_z,
	input  logic signed [fcull_pkg::COORD_W-1:0] second_x,
	input  logic signed [fcull_pkg::COORD_W-1:0] second_y,
	input  logic signed [fcull_pkg::COORD_W-1:0] second_z,
	input  logic [fcull_pkg::RADIUS_W-1:0]       radius,
	output logic                              done,
	output logic                              visible,
	input  logic                              cfg_we,
	input  logic [fcull_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fcull_pkg::CFG_W-1:0]       cfg_wdata
);
	import fcull_pkg::*;

	plane_set_t              planes;
	logic                    valid_s1, valid_s2, done_q;
	logic                    mode_s1;
	logic [RADIUS_W-1:0]     radius_s1;
	coord_t                  lo_s1, hi_s1;
	stage_ctrl_t             ctrl_s2;
	logic [PLANE_COUNT-1:0]  plane_ok;
	logic                    visible_q;

	assign busy = 1'b0;

	fcull_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.planes    (planes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1   <= mode;
			radius_s1 <= radius;
			lo_s1     <= '{x: first_x, y: first_y, z: first_z};
			hi_s1     <= '{x: second_x, y: second_y, z: second_z};
		end
		ctrl_s2   <= '{mode: mode_s1, radius: radius_s1};
		visible_q <= &plane_ok;
	end

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
		fcull_plane_unit u_plane (
			.clk      (clk),
			.plane    (planes[p]),
			.mode_s1  (mode_s1),
			.lo_s1    (lo_s1),
			.hi_s1    (hi_s1),
			.ctrl_s2  (ctrl_s2),
			.plane_ok (plane_ok[p])
		);
	end

	assign done    = done_q;
	assign visible = visible_q;

endmodule

### design/fcull_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_checker
// Port-level checks of the frustum culling test, bound to the top level.
// ----------------------------------------------------------------------------
module fcull_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy was raised although the block takes a transaction every cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("an accepted transaction did not produce a result three cycles later");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("a result appeared without a transaction accepted three cycles earlier");

endmodule

bind frustum_cull_test fcull_checker u_fcull_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
